// ===== design/blire_pkg.sv =====
// Shared constants, codes and types of the bounded list engine.
`default_nettype none
package blire_pkg;

  // List depth and stored value width
  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  // Fixed port field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FPOS_W   = 4;
  localparam int unsigned FILL_W   = 5;

  // Derived widths
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_GET    = 3'd2,
    CMD_SET    = 3'd3,
    CMD_INSERT = 3'd4,
    CMD_REMOVE = 3'd5,
    CMD_FIND   = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_e;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_e;

  // Per-cell control handed from the sequencer to each cell
  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/blire_cell.sv =====
// One list cell: holds an entry, shifts with its neighbors and matches a key.
`default_nettype none
module blire_cell
  import blire_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [VALUE_WIDTH-1:0] wr_data_i,
  input  wire logic [VALUE_WIDTH-1:0] lower_data_i,
  input  wire logic [VALUE_WIDTH-1:0] upper_data_i,
  input  wire logic [VALUE_WIDTH-1:0] key_i,
  output logic      [VALUE_WIDTH-1:0] data_o,
  output logic                        match_o
);

  logic [VALUE_WIDTH-1:0] data_q;
  logic [VALUE_WIDTH-1:0] data_d;

  // Pick the next entry value
  always_comb begin
    case (ctrl_i.op)
      CELL_WRITE:      data_d = wr_data_i;
      CELL_SHIFT_UP:   data_d = lower_data_i;
      CELL_SHIFT_DOWN: data_d = upper_data_i;
      default:         data_d = data_q;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule
`default_nettype wire

// ===== design/bounded_list_insert_remove_engine_unit.sv =====
// Top level of the bounded list engine: command decode, cell row and result register.
`default_nettype none
// Ordered list of up to ENTRIES values held in a row of cells, one entry per cell.
// For every command (push, pop, get, set, insert, remove, find, clear), all cells
// shift, write or compare the key at the same clock edge, and the result lands in
// an output register the cycle after the transaction is accepted. A new transaction
// is taken in every cycle in which the output register is empty or its result is
// taken at the same edge, so the sustained rate is one command per cycle;
// in_stall_o rises only while a result waits on a stalled output. Stored entries
// have no reset; only the entry count and the output valid flag are cleared.
module bounded_list_insert_remove_engine_unit
  import blire_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CMD_W-1:0]    command_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [DATA_W-1:0]   value_in_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [DATA_W-1:0]   value_out_o,
  output logic                     found_o,
  output logic      [FPOS_W-1:0]   found_position_o,
  output logic      [FILL_W-1:0]   fill_count_o
);

  logic                   in_accept;
  cmd_e                   cmd;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [VALUE_WIDTH-1:0] key;
  logic                   is_empty;
  logic                   is_full;
  logic                   pos_in_list;
  logic                   pos_at_most_cnt;

  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       count_d;
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [STATUS_W-1:0]    status_d;
  logic [DATA_W-1:0]      value_q;
  logic [DATA_W-1:0]      value_d;
  logic                   found_q;
  logic                   found_d;
  logic [FPOS_W-1:0]      fpos_q;
  logic [FPOS_W-1:0]      fpos_d;
  logic [FILL_W-1:0]      fill_q;

  logic                   cmd_ok;
  logic                   read_en;
  logic [IDX_W-1:0]       rd_idx;

  cell_ctrl_t             cell_ctrl [ENTRIES];
  logic [VALUE_WIDTH-1:0] cell_data [ENTRIES];
  logic [ENTRIES-1:0]     cell_match;
  logic [ENTRIES-1:0]     hit;
  logic [ENTRIES-1:0]     hit_low;
  logic [IDX_W-1:0]       hit_idx;

  // Accept a transaction when the result slot is free or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign cmd     = cmd_e'(command_i);
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign key     = VALUE_WIDTH'(value_in_i);

  assign is_empty        = (count_q == '0);
  assign is_full         = (count_q == CNT_W'(ENTRIES));
  assign pos_in_list     = (pos_ext < cnt_ext);
  assign pos_at_most_cnt = (pos_ext <= cnt_ext);

  // Decode the command into status, next count and read select
  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    cmd_ok   = 1'b0;
    read_en  = 1'b0;
    rd_idx   = IDX_W'(pos_ext);
    unique case (cmd)
      CMD_PUSH: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          cmd_ok  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP: begin
        rd_idx = IDX_W'(count_q - 1'b1);
        if (is_empty) begin
          status_d = ST_BOUNDS;
        end else begin
          read_en = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      CMD_GET: begin
        if (!pos_in_list) begin
          status_d = ST_BOUNDS;
        end else begin
          read_en = 1'b1;
        end
      end
      CMD_SET: begin
        if (!pos_in_list) begin
          status_d = ST_BOUNDS;
        end else begin
          cmd_ok = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (!pos_at_most_cnt) begin
          status_d = ST_BOUNDS;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else begin
          cmd_ok  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!pos_in_list) begin
          status_d = ST_BOUNDS;
        end else begin
          cmd_ok  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      CMD_FIND: begin
        cmd_ok = 1'b0;
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Drive each cell from its place relative to the position and the count
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_ctrl[i].op = CELL_HOLD;
      if (in_accept && cmd_ok) begin
        case (cmd)
          CMD_PUSH: begin
            if (CMP_W'(i) == cnt_ext) cell_ctrl[i].op = CELL_WRITE;
          end
          CMD_SET: begin
            if (CMP_W'(i) == pos_ext) cell_ctrl[i].op = CELL_WRITE;
          end
          CMD_INSERT: begin
            if (CMP_W'(i) == pos_ext) begin
              cell_ctrl[i].op = CELL_WRITE;
            end else if (CMP_W'(i) > pos_ext) begin
              cell_ctrl[i].op = CELL_SHIFT_UP;
            end
          end
          CMD_REMOVE: begin
            if (CMP_W'(i) >= pos_ext) cell_ctrl[i].op = CELL_SHIFT_DOWN;
          end
          default: begin
            cell_ctrl[i].op = CELL_HOLD;
          end
        endcase
      end
    end
  end

  // Build the cell row with neighbor links
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lower;
    logic [VALUE_WIDTH-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = key;
    end else begin : g_lower
      assign lower = cell_data[g-1];
    end
    if (g == ENTRIES - 1) begin : g_last
      assign upper = cell_data[g];
    end else begin : g_upper
      assign upper = cell_data[g+1];
    end
    blire_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[g]),
      .wr_data_i    (key),
      .lower_data_i (lower),
      .upper_data_i (upper),
      .key_i        (key),
      .data_o       (cell_data[g]),
      .match_o      (cell_match[g])
    );
  end

  // Keep matches of live entries and isolate the lowest one
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = cell_match[i] & (CMP_W'(i) < cnt_ext);
    end
    hit_low = hit & (~hit + 1'b1);
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_low[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  // Form the read value and the find result
  always_comb begin
    value_d = read_en ? DATA_W'(cell_data[rd_idx]) : '0;
    found_d = (cmd == CMD_FIND) && (hit != '0);
    fpos_d  = found_d ? FPOS_W'(hit_idx) : '0;
  end

  // Hold count and valid; advance on an accepted transaction or a drained result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      found_q  <= found_d;
      fpos_q   <= fpos_d;
      fill_q   <= FILL_W'(count_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign value_out_o      = value_q;
  assign found_o          = found_q;
  assign found_position_o = fpos_q;
  assign fill_count_o     = fill_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("entry count exceeds depth");

  a_fill_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fill_count_o == FILL_W'(count_q)))
    else $error("reported fill count differs from held count");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cmd == CMD_PUSH && !is_full) |=>
      (count_q == $past(count_q) + 1'b1) && (status_o == ST_OK))
    else $error("push did not add an entry");

  a_found_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_o) |->
      (status_o == ST_OK) && (FILL_W'(found_position_o) < fill_count_o))
    else $error("find hit outside the list");

  a_error_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o != ST_OK) |-> (value_out_o == '0) && !found_o)
    else $error("error result carries data");
`endif

endmodule
`default_nettype wire
